### hw/rtl/gedd_pkg.sv
package gedd_pkg;

    // item modes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_IRQ   = 2'd1;
    localparam logic [1:0] MODE_WATCH = 2'd2;
    localparam logic [1:0] MODE_STOP  = 2'd3;

    // edge modes
    localparam logic [1:0] EDGE_RISE = 2'd0;
    localparam logic [1:0] EDGE_FALL = 2'd1;
    localparam logic [1:0] EDGE_BOTH = 2'd2;
    localparam logic [1:0] EDGE_BAD  = 2'd3;

    // result kinds
    localparam logic KIND_EVENT  = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    // answer status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BUSY      = 2'd1;
    localparam logic [1:0] ST_BAD_VALUE = 2'd2;
    localparam logic [1:0] ST_UNHANDLED = 2'd3;

    localparam int PIN_W    = 5;
    localparam int STAMP_W  = 32;
    localparam int REQ_DLY_W = 16;
    localparam logic [REQ_DLY_W-1:0] MAX_DEBOUNCE_RST = 16'hFFFF;

    // block sequencer states
    typedef enum logic [2:0] {
        SEQ_IDLE  = 3'b001,
        SEQ_EXEC  = 3'b010,
        SEQ_DRAIN = 3'b100
    } seq_state_t;

    // per-lane command, valid for one cycle
    typedef struct packed {
        logic tick;
        logic irq;
        logic watch_set;
        logic stop;
    } lane_cmd_t;

    // command answer carried into the merge stage
    typedef struct packed {
        logic             valid;
        logic [1:0]       status;
        logic [PIN_W-1:0] pin;
        logic             level;
    } answer_t;

    function automatic logic edge_match(input logic [1:0] m, input logic prev,
                                        input logic now);
        logic r;
        case (m)
            EDGE_RISE: r = !prev && now;
            EDGE_FALL: r = prev && !now;
            EDGE_BOTH: r = prev != now;
            default:   r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/gedd_lane.sv
module gedd_lane
    import gedd_pkg::*;
#(
    parameter int TIME_BITS  = 32,
    parameter int DELAY_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lane_cmd_t             cmd,
    input  logic                  stat_bit,
    input  logic                  level,
    input  logic [1:0]            edge_in,
    input  logic [DELAY_BITS-1:0] delay_in,
    input  logic [TIME_BITS-1:0]  now,
    output logic                  watched,
    output logic                  irq_hit,
    output logic                  fire
);

    localparam int SUM_W = (TIME_BITS > DELAY_BITS) ? TIME_BITS : DELAY_BITS;

    logic                  watch_reg, watch_next;
    logic                  pend_reg, pend_next;
    logic                  last_reg, last_next;
    logic [1:0]            mode_reg, mode_next;
    logic [DELAY_BITS-1:0] dly_reg, dly_next;
    logic [TIME_BITS-1:0]  due_reg, due_next;
    logic [TIME_BITS-1:0]  diff;
    logic [SUM_W-1:0]      due_sum;
    logic                  is_due;

    // due check by signed difference, restart value for an interrupt
    assign diff    = now - due_reg;
    assign is_due  = watch_reg && pend_reg && !diff[TIME_BITS-1];
    assign due_sum = SUM_W'(now) + SUM_W'(dly_reg);
    assign irq_hit = cmd.irq && watch_reg && stat_bit;
    assign fire    = cmd.tick && is_due && edge_match(mode_reg, last_reg, level);
    assign watched = watch_reg;

    // lane state update
    always_comb
    begin
        watch_next = watch_reg;
        pend_next  = pend_reg;
        last_next  = last_reg;
        mode_next  = mode_reg;
        dly_next   = dly_reg;
        due_next   = due_reg;
        if (cmd.tick && is_due)
        begin
            pend_next = 1'b0;
            last_next = level;
        end
        if (irq_hit)
        begin
            pend_next = 1'b1;
            due_next  = due_sum[TIME_BITS-1:0];
        end
        if (cmd.watch_set)
        begin
            mode_next  = edge_in;
            dly_next   = delay_in;
            last_next  = level;
            pend_next  = 1'b0;
            watch_next = 1'b1;
        end
        if (cmd.stop)
        begin
            watch_next = 1'b0;
            pend_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            watch_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            watch_reg <= watch_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        mode_reg <= mode_next;
        dly_reg  <= dly_next;
        due_reg  <= due_next;
    end

endmodule

### hw/rtl/gedd_merge.sv
module gedd_merge
    import gedd_pkg::*;
#(
    parameter int PINS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [PINS-1:0]    fire_vec,
    input  logic [PINS-1:0]    level_vec,
    input  answer_t            answer,
    input  logic [STAMP_W-1:0] stamp,
    output logic               busy,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic [1:0]         status,
    output logic [PIN_W-1:0]   event_pin,
    output logic               event_level,
    output logic [STAMP_W-1:0] time_stamp,
    output logic               last
);

    logic [PINS-1:0]    hit_reg, hit_next;
    logic [PINS-1:0]    lvl_reg;
    answer_t            ans_reg, ans_next;
    logic [STAMP_W-1:0] ts_reg;
    logic [PINS-1:0]    low_bit;
    logic [PINS-1:0]    rest;
    logic [PIN_W-1:0]   low_idx;
    logic               advance;

    logic               ov_reg;
    logic               kind_reg;
    logic [1:0]         status_reg;
    logic [PIN_W-1:0]   pin_reg;
    logic               level_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic               last_reg;

    // lowest pending event in pin order
    assign low_bit = hit_reg & (~hit_reg + PINS'(1));
    assign rest    = hit_reg & ~low_bit;

    always_comb
    begin
        low_idx = '0;
        for (int p = PINS - 1; p >= 0; p--)
        begin
            if (hit_reg[p])
            begin
                low_idx = PIN_W'(p);
            end
        end
    end

    assign busy    = ans_reg.valid || (|hit_reg);
    assign advance = busy && (!ov_reg || out_ready);

    // pending work, answers go out before events
    always_comb
    begin
        hit_next = hit_reg;
        ans_next = ans_reg;
        if (load)
        begin
            hit_next = fire_vec;
            ans_next = answer;
        end
        else if (advance)
        begin
            if (ans_reg.valid)
            begin
                ans_next.valid = 1'b0;
            end
            else
            begin
                hit_next = rest;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= '0;
            ans_reg <= '0;
        end
        else
        begin
            hit_reg <= hit_next;
            ans_reg <= ans_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lvl_reg <= level_vec;
            ts_reg  <= stamp;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (advance)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stamp_reg <= ts_reg;
            if (ans_reg.valid)
            begin
                kind_reg   <= KIND_ANSWER;
                status_reg <= ans_reg.status;
                pin_reg    <= ans_reg.pin;
                level_reg  <= ans_reg.level;
                last_reg   <= 1'b1;
            end
            else
            begin
                kind_reg   <= KIND_EVENT;
                status_reg <= ST_OK;
                pin_reg    <= low_idx;
                level_reg  <= |(lvl_reg & low_bit);
                last_reg   <= ~|rest;
            end
        end
    end

    assign out_valid   = ov_reg;
    assign kind        = kind_reg;
    assign status      = status_reg;
    assign event_pin   = pin_reg;
    assign event_level = level_reg;
    assign time_stamp  = stamp_reg;
    assign last        = last_reg;

endmodule

### hw/rtl/gpio_edge_debounce_dispatch.sv
// GPIO edge debouncer with deferred, pin-ordered dispatch.
// Input channel (in_valid/in_ready) takes one beat per item: tick, interrupt
// status, watch pin or stop watching pin. Output channel (out_valid/out_ready)
// gives result beats; last marks the final beat of an item. A tick gives zero
// or more edge events, every other item gives exactly one command answer.
// cfg_we/cfg_wdata write max_debounce; the user must write it only while the
// block idles, as the block itself does not enforce this. Each item is
// captured into the input registers on acceptance; in the EXEC state all pin
// lanes update in parallel and the merge stage loads; in the DRAIN state the
// merge stage serializes the results, one per cycle to the output register
// while the receiver keeps up, and the block idles once it is empty.
// Reset clears all watch and pending flags, the tick count and the output
// valid flag, and sets max_debounce to 65535.
// When the receiver stalls, results wait in the output register and the
// merge stage; a new item is taken once the previous one has been fully
// handed to the output register, which may still hold its last beat.
module gpio_edge_debounce_dispatch
    import gedd_pkg::*;
#(
    parameter int PINS       = 32,
    parameter int TIME_BITS  = 32,
    parameter int DELAY_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [PIN_W-1:0]   pin,
    input  logic [1:0]         edge_req,
    input  logic [15:0]        debounce_ticks,
    input  logic [31:0]        status_bits,
    input  logic [31:0]        pin_levels,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic [1:0]         status,
    output logic [PIN_W-1:0]   event_pin,
    output logic               event_level,
    output logic [STAMP_W-1:0] time_stamp,
    output logic               last
);

    localparam int CMP_W  = (DELAY_BITS > REQ_DLY_W) ? DELAY_BITS : REQ_DLY_W;
    localparam int TS_W   = (TIME_BITS > STAMP_W) ? TIME_BITS : STAMP_W;
    localparam int PIDX_W = (PINS > 1) ? $clog2(PINS) : 1;

    seq_state_t state_reg, state_next;

    logic [REQ_DLY_W-1:0]  max_deb_reg;
    logic [TIME_BITS-1:0]  tick_reg;
    logic [TIME_BITS-1:0]  now;

    logic [1:0]            mode_reg;
    logic [PIN_W-1:0]      pin_reg;
    logic [1:0]            edge_reg;
    logic [REQ_DLY_W-1:0]  deb_reg;
    logic [31:0]           stat_reg;
    logic [31:0]           lvl_reg;

    logic [CMP_W-1:0]      deb_ext;
    logic [DELAY_BITS-1:0] delay;
    logic                  pin_oor;
    logic                  watch_bad;
    logic                  pin_watched;
    logic                  watch_ok;
    logic                  stop_ok;
    logic                  exec;
    logic [TS_W-1:0]       now_ext;

    logic [PINS-1:0]       watched_vec;
    logic [PINS-1:0]       irq_vec;
    logic [PINS-1:0]       fire_vec;
    answer_t               answer;
    logic                  merge_busy;

    assign in_ready = (state_reg == SEQ_IDLE);
    assign exec     = (state_reg == SEQ_EXEC);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = SEQ_EXEC;
                end
            end
            SEQ_EXEC:
            begin
                state_next = SEQ_DRAIN;
            end
            SEQ_DRAIN:
            begin
                if (!merge_busy)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= SEQ_IDLE;
            max_deb_reg <= MAX_DEBOUNCE_RST;
            tick_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                max_deb_reg <= cfg_wdata;
            end
            if (exec && mode_reg == MODE_TICK)
            begin
                tick_reg <= now;
            end
        end
    end

    // input beat capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg <= mode;
            pin_reg  <= pin;
            edge_reg <= edge_req;
            deb_reg  <= debounce_ticks;
            stat_reg <= status_bits;
            lvl_reg  <= pin_levels;
        end
    end

    // time and request checks
    assign now     = (mode_reg == MODE_TICK) ? tick_reg + TIME_BITS'(1) : tick_reg;
    assign now_ext = TS_W'(now);
    assign deb_ext = CMP_W'(deb_reg);
    assign delay   = deb_ext[DELAY_BITS-1:0];

    assign pin_oor     = 32'(pin_reg) >= 32'(PINS);
    assign pin_watched = !pin_oor && watched_vec[pin_reg[PIDX_W-1:0]];
    assign watch_bad   = pin_oor || (edge_reg == EDGE_BAD)
                         || (CMP_W'(delay) > CMP_W'(max_deb_reg));
    assign watch_ok    = (mode_reg == MODE_WATCH) && !watch_bad && !pin_watched;
    assign stop_ok     = (mode_reg == MODE_STOP) && !pin_oor;

    // command answer
    always_comb
    begin
        answer.valid  = exec && (mode_reg != MODE_TICK);
        answer.status = ST_OK;
        answer.pin    = pin_reg;
        answer.level  = 1'b0;
        unique case (mode_reg)
            MODE_IRQ:
            begin
                answer.pin    = '0;
                answer.status = (|irq_vec) ? ST_OK : ST_UNHANDLED;
            end
            MODE_WATCH:
            begin
                if (watch_bad)
                begin
                    answer.status = ST_BAD_VALUE;
                end
                else if (pin_watched)
                begin
                    answer.status = ST_BUSY;
                end
                else
                begin
                    answer.level = lvl_reg[pin_reg];
                end
            end
            MODE_STOP:
            begin
                answer.status = pin_oor ? ST_BAD_VALUE : ST_OK;
            end
            default:
            begin
                answer.status = ST_OK;
            end
        endcase
    end

    // one lane per pin
    for (genvar i = 0; i < PINS; i++)
    begin : g_lane
        lane_cmd_t cmd;
        logic      sel;

        assign sel           = (pin_reg == PIN_W'(i));
        assign cmd.tick      = exec && (mode_reg == MODE_TICK);
        assign cmd.irq       = exec && (mode_reg == MODE_IRQ);
        assign cmd.watch_set = exec && watch_ok && sel;
        assign cmd.stop      = exec && stop_ok && sel;

        gedd_lane #(
            .TIME_BITS  (TIME_BITS),
            .DELAY_BITS (DELAY_BITS)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .stat_bit (stat_reg[i]),
            .level    (lvl_reg[i]),
            .edge_in  (edge_reg),
            .delay_in (delay),
            .now      (now),
            .watched  (watched_vec[i]),
            .irq_hit  (irq_vec[i]),
            .fire     (fire_vec[i])
        );
    end

    // merge and output stage
    gedd_merge #(
        .PINS (PINS)
    ) u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (exec),
        .fire_vec    (fire_vec),
        .level_vec   (lvl_reg[PINS-1:0]),
        .answer      (answer),
        .stamp       (now_ext[STAMP_W-1:0]),
        .busy        (merge_busy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .status      (status),
        .event_pin   (event_pin),
        .event_level (event_level),
        .time_stamp  (time_stamp),
        .last        (last)
    );

endmodule

### tb/sv/tb_gpio_edge_debounce_dispatch.sv
`timescale 1ns / 1ps

module tb_gpio_edge_debounce_dispatch;
    import gedd_pkg::*;

    localparam int NPINS         = 32;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_CYCLES  = 400;

    // one result beat as seen on the output channel
    typedef struct packed {
        logic             kind;
        logic [1:0]       status;
        logic [PIN_W-1:0] pin;
        logic             level;
        logic [31:0]      stamp;
        logic             last;
    } beat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [15:0]        cfg_wdata = 16'd0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         mode = MODE_TICK;
    logic [PIN_W-1:0]   pin = '0;
    logic [1:0]         edge_req = EDGE_RISE;
    logic [15:0]        debounce_ticks = 16'd0;
    logic [31:0]        status_bits = 32'd0;
    logic [31:0]        pin_levels = 32'd0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               kind;
    logic [1:0]         status;
    logic [PIN_W-1:0]   event_pin;
    logic               event_level;
    logic [STAMP_W-1:0] time_stamp;
    logic               last;

    // predicted pin state
    logic [NPINS-1:0] armed;
    logic [NPINS-1:0] pend;
    logic [NPINS-1:0] lvl_prev;
    logic [1:0]       emode [NPINS];
    logic [15:0]      dly [NPINS];
    logic [31:0]      due_at [NPINS];
    logic [31:0]      now_tick;
    logic [15:0]      dly_limit;

    beat_t out_beat_q[$];
    int    err_cnt = 0;

    // idling controls
    int   src_idle = 0;
    int   drain_idle_pct = 0;
    logic stall_tgl = 1'b0;
    logic stall_seen = 1'b0;
    int   stall_left = 0;

    gpio_edge_debounce_dispatch u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .pin            (pin),
        .edge_req       (edge_req),
        .debounce_ticks (debounce_ticks),
        .status_bits    (status_bits),
        .pin_levels     (pin_levels),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .status         (status),
        .event_pin      (event_pin),
        .event_level    (event_level),
        .time_stamp     (time_stamp),
        .last           (last)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // hard limit on run time
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic edge_fires(input logic [1:0] m, input logic was,
                                        input logic now);
        case (m)
            EDGE_RISE: return !was && now;
            EDGE_FALL: return was && !now;
            EDGE_BOTH: return was != now;
            default:   return 1'b0;
        endcase
    endfunction

    task automatic clear_pin_state();
        armed     = '0;
        pend      = '0;
        lvl_prev  = '0;
        now_tick  = '0;
        dly_limit = MAX_DEBOUNCE_RST;
        for (int p = 0; p < NPINS; p++)
        begin
            emode[p]  = EDGE_RISE;
            dly[p]    = '0;
            due_at[p] = '0;
        end
    endtask

    // advance predicted state by one item and queue the beats it causes
    task automatic debounce_step(input logic [1:0] md, input logic [PIN_W-1:0] pn,
                                 input logic [1:0] eg, input logic [15:0] dl,
                                 input logic [31:0] st, input logic [31:0] lv);
        beat_t       b;
        beat_t       evts [NPINS];
        int          n;
        logic [31:0] diff;
        logic [31:0] hits;
        b = '0;
        b.kind = KIND_ANSWER;
        b.last = 1'b1;
        b.pin  = pn;
        case (md)
            MODE_TICK:
            begin
                now_tick = now_tick + 32'd1;
                n = 0;
                for (int p = 0; p < NPINS; p++)
                begin
                    if (armed[p] && pend[p])
                    begin
                        diff = now_tick - due_at[p];
                        if (!diff[31])
                        begin
                            pend[p] = 1'b0;
                            if (edge_fires(emode[p], lvl_prev[p], lv[p]))
                            begin
                                evts[n] = '0;
                                evts[n].kind   = KIND_EVENT;
                                evts[n].status = ST_OK;
                                evts[n].pin    = PIN_W'(p);
                                evts[n].level  = lv[p];
                                evts[n].stamp  = now_tick;
                                n++;
                            end
                            lvl_prev[p] = lv[p];
                        end
                    end
                end
                for (int i = 0; i < n; i++)
                begin
                    evts[i].last = (i == n - 1);
                    out_beat_q.push_back(evts[i]);
                end
            end
            MODE_IRQ:
            begin
                hits = st & armed;
                for (int p = 0; p < NPINS; p++)
                begin
                    if (hits[p])
                    begin
                        pend[p]   = 1'b1;
                        due_at[p] = now_tick + {16'd0, dly[p]};
                    end
                end
                b.status = (hits != 0) ? ST_OK : ST_UNHANDLED;
                b.pin    = '0;
                b.stamp  = now_tick;
                out_beat_q.push_back(b);
            end
            MODE_WATCH:
            begin
                if (eg == EDGE_BAD || dl > dly_limit)
                    b.status = ST_BAD_VALUE;
                else if (armed[pn])
                    b.status = ST_BUSY;
                else
                begin
                    emode[pn]    = eg;
                    dly[pn]      = dl;
                    lvl_prev[pn] = lv[pn];
                    pend[pn]     = 1'b0;
                    armed[pn]    = 1'b1;
                    b.status     = ST_OK;
                    b.level      = lv[pn];
                end
                b.stamp = now_tick;
                out_beat_q.push_back(b);
            end
            default:
            begin
                armed[pn] = 1'b0;
                pend[pn]  = 1'b0;
                b.status  = ST_OK;
                b.stamp   = now_tick;
                out_beat_q.push_back(b);
            end
        endcase
    endtask

    // offer one input beat, wait for acceptance, then predict
    task automatic send_item(input logic [1:0] md, input logic [PIN_W-1:0] pn,
                             input logic [1:0] eg, input logic [15:0] dl,
                             input logic [31:0] st, input logic [31:0] lv);
        if (src_idle > 0 && $urandom_range(99) < src_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle);
        end
        in_valid       <= 1'b1;
        mode           <= md;
        pin            <= pn;
        edge_req       <= eg;
        debounce_ticks <= dl;
        status_bits    <= st;
        pin_levels     <= lv;
        do
            @(posedge clk);
        while (!in_ready);
        debounce_step(md, pn, eg, dl, st, lv);
    endtask

    task automatic send_random_item();
        int          r;
        logic [1:0]  md;
        logic [1:0]  eg;
        logic [15:0] dl;
        logic [31:0] st;
        r  = $urandom_range(99);
        md = (r < 45) ? MODE_TICK : (r < 70) ? MODE_IRQ : (r < 90) ? MODE_WATCH : MODE_STOP;
        eg = ($urandom_range(9) == 0) ? EDGE_BAD : 2'($urandom_range(2));
        dl = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6));
        st = ($urandom_range(4) == 0) ? 32'd0 : $urandom;
        send_item(md, PIN_W'($urandom_range(31)), eg, dl, st, $urandom);
    endtask

    // let every expected beat arrive and the block settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (out_beat_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_debounce_limit(input logic [15:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        dly_limit = v;
    endtask

    task automatic set_idling(input int src_pct, input int dst_pct);
        src_idle = src_pct;
        drain_idle_pct <= dst_pct;
    endtask

    // interrupt answer and an empty tick on an empty block
    task automatic test_idle_answers();
        send_item(MODE_IRQ, '0, EDGE_RISE, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_TICK, '1, EDGE_BAD, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
    endtask

    // watch ok, busy, bad edge, extreme delay
    task automatic test_watch_requests();
        send_item(MODE_WATCH, 5'd0, EDGE_RISE, 16'd0, 32'd0, 32'd0);
        send_item(MODE_WATCH, 5'd31, EDGE_FALL, 16'd2, 32'd0, 32'hFFFF_FFFF);
        send_item(MODE_WATCH, 5'd5, EDGE_BOTH, 16'd1, 32'd0, 32'h0000_0020);
        send_item(MODE_WATCH, 5'd0, EDGE_BOTH, 16'd3, 32'd0, 32'hFFFF_FFFF);
        send_item(MODE_WATCH, 5'd7, EDGE_BAD, 16'd1, 32'd0, 32'd0);
        send_item(MODE_WATCH, 5'd9, EDGE_BOTH, 16'hFFFF, 32'd0, 32'd0);
    endtask

    // pending pins, restart on a pending pin, edges that do and do not match
    task automatic test_irq_dispatch();
        send_item(MODE_IRQ, '0, EDGE_RISE, 16'd0, 32'hFFFF_FFFF, 32'd0);
        send_item(MODE_TICK, '0, EDGE_RISE, 16'd0, 32'd0, 32'hFFFF_FFFF);
        send_item(MODE_IRQ, '0, EDGE_RISE, 16'd0, 32'h0000_0001, 32'd0);
        send_item(MODE_TICK, '0, EDGE_RISE, 16'd0, 32'd0, 32'd0);
        send_item(MODE_IRQ, '0, EDGE_RISE, 16'd0, 32'h0000_0020, 32'd0);
        send_item(MODE_IRQ, '0, EDGE_RISE, 16'd0, 32'h0000_0020, 32'd0);
        send_item(MODE_TICK, '0, EDGE_RISE, 16'd0, 32'd0, 32'd0);
        send_item(MODE_TICK, '0, EDGE_RISE, 16'd0, 32'd0, 32'hFFFF_FFFF);
        send_item(MODE_TICK, '0, EDGE_RISE, 16'd0, 32'd0, 32'd0);
    endtask

    // stop a watched pin, an unwatched pin, the top pin
    task automatic test_stop_requests();
        send_item(MODE_STOP, 5'd0, EDGE_RISE, 16'd0, 32'd0, 32'd0);
        send_item(MODE_STOP, 5'd0, EDGE_RISE, 16'd0, 32'd0, 32'd0);
        send_item(MODE_STOP, 5'd31, EDGE_RISE, 16'd0, 32'd0, 32'd0);
    endtask

    // delay limit at its lowest, then back to its highest
    task automatic test_delay_limit();
        write_debounce_limit(16'd0);
        send_item(MODE_WATCH, 5'd12, EDGE_RISE, 16'd1, 32'd0, 32'd0);
        send_item(MODE_WATCH, 5'd12, EDGE_RISE, 16'd0, 32'd0, 32'hFFFF_FFFF);
        write_debounce_limit(16'hFFFF);
    endtask

    task automatic test_random_traffic(input int count, input int src_pct,
                                       input int dst_pct, input logic [15:0] limit);
        write_debounce_limit(limit);
        set_idling(src_pct, dst_pct);
        repeat (count) send_random_item();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure(input int count);
        wait_drained();
        set_idling(0, 0);
        stall_tgl <= ~stall_tgl;
        repeat (count) send_random_item();
    endtask

    // receiver ready except for random idling, with an occasional long hold-off
    always @(posedge clk)
    begin
        if (stall_tgl != stall_seen)
        begin
            stall_seen <= stall_tgl;
            stall_left <= STALL_CYCLES;
            out_ready  <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= drain_idle_pct);
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            err_cnt++;
        end
    endtask

    // compare each accepted result beat with the oldest prediction
    always @(posedge clk)
    begin : beat_check
        beat_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (out_beat_q.size() == 0)
            begin
                $error("result beat with nothing expected: pin %0d", event_pin);
                err_cnt++;
            end
            else
            begin
                want = out_beat_q.pop_front();
                check_field("kind", 32'(want.kind), 32'(kind));
                check_field("status", 32'(want.status), 32'(status));
                check_field("event_pin", 32'(want.pin), 32'(event_pin));
                check_field("event_level", 32'(want.level), 32'(event_level));
                check_field("time_stamp", want.stamp, time_stamp);
                check_field("last", 32'(want.last), 32'(last));
            end
        end
    end

    // test sequence
    initial
    begin
        clear_pin_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_answers();
        test_watch_requests();
        test_irq_dispatch();
        test_stop_requests();
        test_delay_limit();
        test_random_traffic(110, 24, 86, 16'hFFFF);
        test_random_traffic(110, 86, 24, 16'($urandom_range(1, 6)));
        test_backpressure(30);
        test_random_traffic(110, 0, 0, 16'd40000);
        wait_drained();
        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
